[rtl/core/mld_pkg.sv]
// Shared types, constants and the Morse code table for the Morse light decoder.
package mld_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DASH_TICKS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_TICKS     = 2'd2;

  localparam int unsigned THRESH_W = 12;
  localparam int unsigned TICKS_W  = 8;
  localparam int unsigned CFG_W    = 12;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd50;
  localparam logic [TICKS_W-1:0]  DASH_RESET   = 8'd6;
  localparam logic [TICKS_W-1:0]  SPACE_RESET  = 8'd8;

  // Tick counter: 16 bits, saturating.
  localparam int unsigned TICK_W = 16;
  localparam logic [TICK_W-1:0] TICK_RESET = 16'd14;
  localparam logic [TICK_W-1:0] TICK_MAX   = 16'hFFFF;

  localparam int unsigned CHAR_W = 7;
  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;

  typedef enum logic [1:0] {
    KIND_DECODED = 2'd0,
    KIND_UNKNOWN = 2'd1,
    KIND_SPACE   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    kind_e             char_kind;
  } result_t;

  // Looks a held symbol pattern up in the code table (bit k is symbol k,
  // set for a dash). Returns zero when the pattern has no character.
  function automatic logic [CHAR_W-1:0] mld_decode(input logic [7:0] len,
                                                   input logic [7:0] bits);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    if (len[7:3] == 5'd0 && bits[7:5] == 3'd0) begin
      case ({len[2:0], bits[4:0]})
        {3'd2, 5'd2}:  ch = 7'h41;
        {3'd4, 5'd1}:  ch = 7'h42;
        {3'd4, 5'd5}:  ch = 7'h43;
        {3'd3, 5'd1}:  ch = 7'h44;
        {3'd1, 5'd0}:  ch = 7'h45;
        {3'd4, 5'd4}:  ch = 7'h46;
        {3'd3, 5'd3}:  ch = 7'h47;
        {3'd4, 5'd0}:  ch = 7'h48;
        {3'd2, 5'd0}:  ch = 7'h49;
        {3'd4, 5'd14}: ch = 7'h4A;
        {3'd3, 5'd5}:  ch = 7'h4B;
        {3'd4, 5'd2}:  ch = 7'h4C;
        {3'd2, 5'd3}:  ch = 7'h4D;
        {3'd2, 5'd1}:  ch = 7'h4E;
        {3'd3, 5'd7}:  ch = 7'h4F;
        {3'd4, 5'd6}:  ch = 7'h50;
        {3'd4, 5'd11}: ch = 7'h51;
        {3'd3, 5'd2}:  ch = 7'h52;
        {3'd3, 5'd0}:  ch = 7'h53;
        {3'd1, 5'd1}:  ch = 7'h54;
        {3'd3, 5'd4}:  ch = 7'h55;
        {3'd4, 5'd8}:  ch = 7'h56;
        {3'd3, 5'd6}:  ch = 7'h57;
        {3'd4, 5'd9}:  ch = 7'h58;
        {3'd4, 5'd13}: ch = 7'h59;
        {3'd4, 5'd3}:  ch = 7'h5A;
        {3'd5, 5'd31}: ch = 7'h30;
        {3'd5, 5'd30}: ch = 7'h31;
        {3'd5, 5'd28}: ch = 7'h32;
        {3'd5, 5'd24}: ch = 7'h33;
        {3'd5, 5'd16}: ch = 7'h34;
        {3'd5, 5'd0}:  ch = 7'h35;
        {3'd5, 5'd1}:  ch = 7'h36;
        {3'd5, 5'd3}:  ch = 7'h37;
        {3'd5, 5'd7}:  ch = 7'h38;
        {3'd5, 5'd15}: ch = 7'h39;
        default:       ch = '0;
      endcase
    end
    return ch;
  endfunction

endpackage

[rtl/core/morse_light_decoder_unit.sv]
// Top level of the Morse light decoder: configuration registers, front and back stages.
//
// Input channel: one light sample beat per tick on light_sample_i, taken at a rising
// edge with push high and full low. Each beat yields zero or one character.
// Result channel: while empty is low the oldest character is on out_char_o and
// char_kind_o (0 letter or digit, 1 unknown pattern, 2 word space); it is taken at a
// rising edge with pop high and empty low.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 threshold,
// 1 dash ticks, 2 space ticks) in the same edge; write only while the block is idle.
// Path: a character caused by a sample beat is registered in the classification queue,
// then in the result queue. Throughput: one sample beat per cycle while the two-entry
// result queue has a free slot, set by the state update in the back stage.
// A two-entry queue between the classifying front stage and the back stage lets
// either side stall independently. When the receiver stops popping, the result
// queue fills, the back stage holds, and full rises once two more beats are taken.
// Reset clears both queues and the decoder state and restores the register defaults;
// the tick counter restarts at 14.
module morse_light_decoder_unit #(
  parameter int unsigned MAX_SYMBOLS  = 5,
  parameter int unsigned SAMPLE_WIDTH = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [SAMPLE_WIDTH-1:0]       light_sample_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [mld_pkg::CHAR_W-1:0]    out_char_o,
  output logic [1:0]                    char_kind_o,
  input  logic                          cfg_we_i,
  input  logic [mld_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mld_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import mld_pkg::*;

  logic [THRESH_W-1:0] threshold_q;
  logic [TICKS_W-1:0]  dash_ticks_q;
  logic [TICKS_W-1:0]  space_ticks_q;

  logic    cls_valid, cls_on, cls_pop;
  logic    res_push, res_full;
  result_t res, res_head;

  // Configuration registers; writes to indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= THRESH_RESET;
      dash_ticks_q  <= DASH_RESET;
      space_ticks_q <= SPACE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LIGHT_THRESHOLD: threshold_q   <= cfg_wdata_i[THRESH_W-1:0];
        CFG_DASH_TICKS:      dash_ticks_q  <= cfg_wdata_i[TICKS_W-1:0];
        CFG_SPACE_TICKS:     space_ticks_q <= cfg_wdata_i[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  mld_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .light_sample_i(light_sample_i),
    .full_o        (full),
    .threshold_i   (threshold_q),
    .cls_valid_o   (cls_valid),
    .cls_on_o      (cls_on),
    .cls_pop_i     (cls_pop)
  );

  mld_back #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cls_valid_i  (cls_valid),
    .cls_on_i     (cls_on),
    .cls_pop_o    (cls_pop),
    .dash_ticks_i (dash_ticks_q),
    .space_ticks_i(space_ticks_q),
    .res_push_o   (res_push),
    .res_o        (res),
    .res_full_i   (res_full)
  );

  // Result queue: decouples the back stage from the receiver.
  mld_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(2)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(res_head)
  );

  assign out_char_o  = res_head.out_char;
  assign char_kind_o = res_head.char_kind;

endmodule

[rtl/core/mld_fifo.sv]
// Small register queue with first-word fall-through, used between the stages and as the result queue.
module mld_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/core/mld_front.sv]
// Front stage: takes sample beats, classifies light on or off and queues the result.
module mld_front #(
  parameter int unsigned SAMPLE_WIDTH = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [SAMPLE_WIDTH-1:0]      light_sample_i,
  output logic                         full_o,
  input  logic [mld_pkg::THRESH_W-1:0] threshold_i,
  output logic                         cls_valid_o,
  output logic                         cls_on_o,
  input  logic                         cls_pop_i
);
  import mld_pkg::*;

  localparam int unsigned CMP_W = (SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W;

  logic light_on;
  logic cls_empty;

  // A sample strictly above the threshold counts as light on.
  assign light_on = (CMP_W'(light_sample_i) > CMP_W'(threshold_i));

  mld_fifo #(
    .WIDTH(1),
    .DEPTH(2)
  ) u_cls_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .wdata_i(light_on),
    .full_o (full_o),
    .pop_i  (cls_pop_i),
    .empty_o(cls_empty),
    .rdata_o(cls_on_o)
  );

  assign cls_valid_o = !cls_empty;

endmodule

[rtl/core/mld_back.sv]
// Back stage: edge detection, symbol collection, gap timing and letter decode.
module mld_back #(
  parameter int unsigned MAX_SYMBOLS = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cls_valid_i,
  input  logic                        cls_on_i,
  output logic                        cls_pop_o,
  input  logic [mld_pkg::TICKS_W-1:0] dash_ticks_i,
  input  logic [mld_pkg::TICKS_W-1:0] space_ticks_i,
  output logic                        res_push_o,
  output mld_pkg::result_t            res_o,
  input  logic                        res_full_i
);
  import mld_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SYMBOLS + 1);

  logic                   was_on_q, was_on_d;
  logic [TICK_W-1:0]      tick_q, tick_d;
  logic [CNT_W-1:0]       sym_cnt_q, sym_cnt_d;
  logic [MAX_SYMBOLS-1:0] sym_pat_q, sym_pat_d;
  logic                   sym_ovf_q, sym_ovf_d;

  logic                   step;
  logic                   fall, rise;
  logic [TICK_W-1:0]      tick_edge;
  logic [TICK_W:0]        tick_inc;
  logic [CHAR_W-1:0]      dec_char;

  // One classified beat is processed whenever the result queue has room.
  assign step      = cls_valid_i && !res_full_i;
  assign cls_pop_o = step;
  assign fall      = was_on_q && !cls_on_i;
  assign rise      = !was_on_q && cls_on_i;

  // Next state and result for one beat.
  always_comb begin
    was_on_d   = was_on_q;
    tick_d     = tick_q;
    sym_cnt_d  = sym_cnt_q;
    sym_pat_d  = sym_pat_q;
    sym_ovf_d  = sym_ovf_q;
    res_push_o = 1'b0;
    res_o      = '{out_char: CHAR_SPACE, char_kind: KIND_SPACE};
    tick_edge  = (fall || rise) ? '0 : tick_q;
    tick_inc   = {1'b0, tick_edge} + (TICK_W + 1)'(1);
    dec_char   = '0;

    if (step) begin
      // A falling edge appends a symbol, or marks overflow when the buffer is full.
      if (fall) begin
        if (sym_cnt_q < CNT_W'(MAX_SYMBOLS)) begin
          if (tick_q >= TICK_W'(dash_ticks_i)) begin
            sym_pat_d = sym_pat_q | (MAX_SYMBOLS'(1) << sym_cnt_q);
          end
          sym_cnt_d = sym_cnt_q + CNT_W'(1);
        end else begin
          sym_ovf_d = 1'b1;
        end
      end
      was_on_d = cls_on_i;

      dec_char = mld_decode(8'(sym_cnt_d), 8'(sym_pat_d));

      // Gap timing while the light is off.
      if (!cls_on_i) begin
        if (sym_cnt_d != '0) begin
          if (tick_inc == (TICK_W + 1)'(dash_ticks_i)) begin
            res_push_o = 1'b1;
            if (!sym_ovf_d && dec_char != '0) begin
              res_o = '{out_char: dec_char, char_kind: KIND_DECODED};
            end else begin
              res_o = '{out_char: CHAR_UNKNOWN, char_kind: KIND_UNKNOWN};
            end
            sym_cnt_d = '0;
            sym_pat_d = '0;
            sym_ovf_d = 1'b0;
          end
        end else if (tick_inc == (TICK_W + 1)'(space_ticks_i)) begin
          res_push_o = 1'b1;
          res_o      = '{out_char: CHAR_SPACE, char_kind: KIND_SPACE};
        end
      end

      // The tick counter saturates at its maximum.
      tick_d = (tick_edge < TICK_MAX) ? tick_inc[TICK_W-1:0] : tick_edge;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_on_q  <= 1'b0;
      tick_q    <= TICK_RESET;
      sym_cnt_q <= '0;
      sym_pat_q <= '0;
      sym_ovf_q <= 1'b0;
    end else begin
      was_on_q  <= was_on_d;
      tick_q    <= tick_d;
      sym_cnt_q <= sym_cnt_d;
      sym_pat_q <= sym_pat_d;
      sym_ovf_q <= sym_ovf_d;
    end
  end

endmodule

[rtl/core/mld_checker.sv]
// Port-level checks for the Morse light decoder, bound to the top level.
module mld_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [6:0] out_char_o,
  input logic [1:0] char_kind_o
);
  import mld_pkg::*;

  // A waiting result beat that is not taken stays and keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_char_o) && $stable(char_kind_o)))
    else $error("stalled result beat changed");

  // A word space always carries the space character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && char_kind_o == KIND_SPACE) |-> (out_char_o == CHAR_SPACE))
    else $error("space beat with wrong character");

  // An unknown pattern always carries the question mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && char_kind_o == KIND_UNKNOWN) |-> (out_char_o == CHAR_UNKNOWN))
    else $error("unknown beat with wrong character");

  // A decoded beat is a capital letter or a digit, and no other kind code appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && char_kind_o == KIND_DECODED) |->
      ((out_char_o >= 7'h41 && out_char_o <= 7'h5A) ||
       (out_char_o >= 7'h30 && out_char_o <= 7'h39)))
    else $error("decoded beat outside letters and digits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (char_kind_o == KIND_DECODED || char_kind_o == KIND_UNKNOWN ||
                char_kind_o == KIND_SPACE))
    else $error("undefined kind code on result beat");

endmodule

bind morse_light_decoder_unit mld_checker u_mld_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_char_o (out_char_o),
  .char_kind_o(char_kind_o)
);
